FILE: src/ps2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_pkg
// Shared constants, types and key tables for the scan-code to ASCII unit.
// ----------------------------------------------------------------------------
package ps2a_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] SC_PREFIX      = 8'hE0;
    localparam logic [7:0] SC_BREAK_BIT   = 8'h80;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
    localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
    localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
    localparam logic [7:0] SC_CAPS_BRK    = 8'hBA;

    localparam logic [6:0] CASE_OFFSET = 7'd32;
    localparam logic [6:0] ASCII_LC_A  = 7'h61;
    localparam logic [6:0] ASCII_LC_Z  = 7'h7A;

    typedef logic [6:0] char_t;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } kbd_flags_t;

    typedef struct packed {
        logic pop_ok;
        logic not_empty;
    } fifo_status_t;

    // US layout, unshifted
    function automatic char_t plain_key(input logic [7:0] code);
        char_t ch;
        case (code)
            8'h01: ch = 7'h1B;  8'h02: ch = 7'h31;  8'h03: ch = 7'h32;  8'h04: ch = 7'h33;
            8'h05: ch = 7'h34;  8'h06: ch = 7'h35;  8'h07: ch = 7'h36;  8'h08: ch = 7'h37;
            8'h09: ch = 7'h38;  8'h0A: ch = 7'h39;  8'h0B: ch = 7'h30;  8'h0C: ch = 7'h2D;
            8'h0D: ch = 7'h3D;  8'h0E: ch = 7'h08;  8'h0F: ch = 7'h09;  8'h10: ch = 7'h71;
            8'h11: ch = 7'h77;  8'h12: ch = 7'h65;  8'h13: ch = 7'h72;  8'h14: ch = 7'h74;
            8'h15: ch = 7'h79;  8'h16: ch = 7'h75;  8'h17: ch = 7'h69;  8'h18: ch = 7'h6F;
            8'h19: ch = 7'h70;  8'h1A: ch = 7'h5B;  8'h1B: ch = 7'h5D;  8'h1C: ch = 7'h0A;
            8'h1E: ch = 7'h61;  8'h1F: ch = 7'h73;  8'h20: ch = 7'h64;  8'h21: ch = 7'h66;
            8'h22: ch = 7'h67;  8'h23: ch = 7'h68;  8'h24: ch = 7'h6A;  8'h25: ch = 7'h6B;
            8'h26: ch = 7'h6C;  8'h27: ch = 7'h3B;  8'h28: ch = 7'h27;  8'h29: ch = 7'h60;
            8'h2B: ch = 7'h5C;  8'h2C: ch = 7'h7A;  8'h2D: ch = 7'h78;  8'h2E: ch = 7'h63;
            8'h2F: ch = 7'h76;  8'h30: ch = 7'h62;  8'h31: ch = 7'h6E;  8'h32: ch = 7'h6D;
            8'h33: ch = 7'h2C;  8'h34: ch = 7'h2E;  8'h35: ch = 7'h2F;  8'h37: ch = 7'h2A;
            8'h39: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // US layout, shifted; only the non-letter keys that change are listed
    function automatic char_t shifted_key(input logic [7:0] code);
        char_t ch;
        case (code)
            8'h02: ch = 7'h21;  8'h03: ch = 7'h40;  8'h04: ch = 7'h23;  8'h05: ch = 7'h24;
            8'h06: ch = 7'h25;  8'h07: ch = 7'h5E;  8'h08: ch = 7'h26;  8'h09: ch = 7'h2A;
            8'h0A: ch = 7'h28;  8'h0B: ch = 7'h29;  8'h0C: ch = 7'h5F;  8'h0D: ch = 7'h2B;
            8'h27: ch = 7'h3A;  8'h28: ch = 7'h22;  8'h29: ch = 7'h7E;  8'h2B: ch = 7'h7C;
            8'h33: ch = 7'h3C;  8'h34: ch = 7'h3E;  8'h35: ch = 7'h3F;
            default: ch = plain_key(code);
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: src/ps2a_keymap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_keymap
// Modifier/prefix tracking and set 1 make-code to ASCII translation.
// ----------------------------------------------------------------------------
module ps2a_keymap (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [7:0]           code,
    output ps2a_pkg::kbd_flags_t      flags_next,
    output ps2a_pkg::char_t           ch
);

    ps2a_pkg::kbd_flags_t flags_reg;
    logic                 prefix_reg;
    logic                 prefix_next;
    ps2a_pkg::char_t      base;

    always_comb
    begin
        flags_next  = flags_reg;
        prefix_next = prefix_reg;
        ch          = '0;
        base        = ps2a_pkg::plain_key(code);
        if (en)
        begin
            if (code == ps2a_pkg::SC_PREFIX)
            begin
                prefix_next = 1'b1;
            end
            else if (prefix_reg)
            begin
                // byte after the extended prefix is swallowed
                prefix_next = 1'b0;
            end
            else
            begin
                unique case (code) inside
                    ps2a_pkg::SC_LSHIFT_BRK, ps2a_pkg::SC_RSHIFT_BRK: flags_next.shift = 1'b0;
                    ps2a_pkg::SC_CTRL_BRK:                            flags_next.ctrl  = 1'b0;
                    ps2a_pkg::SC_ALT_BRK:                             flags_next.alt   = 1'b0;
                    ps2a_pkg::SC_LSHIFT_MAKE, ps2a_pkg::SC_RSHIFT_MAKE: flags_next.shift = 1'b1;
                    ps2a_pkg::SC_CTRL_MAKE:                           flags_next.ctrl  = 1'b1;
                    ps2a_pkg::SC_ALT_MAKE:                            flags_next.alt   = 1'b1;
                    ps2a_pkg::SC_CAPS_MAKE:                           flags_next.caps  = ~flags_reg.caps;
                    default:
                    begin
                        // caps break and all other breaks fall here and give nothing
                        if ((code & ps2a_pkg::SC_BREAK_BIT) == 8'h00)
                        begin
                            if (base >= ps2a_pkg::ASCII_LC_A && base <= ps2a_pkg::ASCII_LC_Z)
                            begin
                                ch = (flags_reg.shift ^ flags_reg.caps)
                                   ? base - ps2a_pkg::CASE_OFFSET : base;
                            end
                            else if (flags_reg.shift)
                            begin
                                ch = ps2a_pkg::shifted_key(code);
                            end
                            else
                            begin
                                ch = base;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            prefix_reg <= 1'b0;
        end
        else
        begin
            flags_reg  <= flags_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/ps2a_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_fifo
// Ring buffer of characters, one slot kept free; registered read data.
// ----------------------------------------------------------------------------
module ps2a_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_req,
    input  wire ps2a_pkg::char_t      push_data,
    input  wire logic                 pop_req,
    output ps2a_pkg::char_t           rd_data,
    output ps2a_pkg::fifo_status_t    status
);

    localparam logic [ps2a_pkg::PTR_W-1:0] LAST_IDX =
        ps2a_pkg::PTR_W'(ps2a_pkg::FIFO_DEPTH - 1);

    ps2a_pkg::char_t            mem [ps2a_pkg::FIFO_DEPTH];
    ps2a_pkg::char_t            rd_data_reg;
    logic [ps2a_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ps2a_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ps2a_pkg::PTR_W-1:0] wr_inc, rd_inc;
    logic                       empty, full, do_push;

    always_comb
    begin
        wr_inc      = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        rd_inc      = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        empty       = (wr_ptr_reg == rd_ptr_reg);
        full        = (wr_inc == rd_ptr_reg);
        do_push     = push_req && !full;
        status.pop_ok = pop_req && !empty;
        wr_ptr_next = do_push ? wr_inc : wr_ptr_reg;
        rd_ptr_next = status.pop_ok ? rd_inc : rd_ptr_reg;
        status.not_empty = (wr_ptr_next != rd_ptr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // push and pop never come in the same item; a read request loads rd_data_reg even from an empty queue
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop_req)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: src/ps2_scancode_to_ascii_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Result: registered at input accept and shown on the master side in the cycle after.
// Throughput: one item per cycle; the result register stalls input only
// while a result waits and m_axis_tready is low.
// Reset: pointers, modifier/caps/prefix flags, echo enable and output valid
// clear at once; character storage is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_fifo_unit
// Set 1 scan codes in, ASCII receive queue with host reads and echo.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_fifo_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,     // echo_enable
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] scan_byte
    input  wire logic [0:0]  s_axis_tuser,    // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] read_char, [7] read_valid, [14:8] echo_char, [15] echo_valid,
    // [16] key_available, [17] shift_held, [18] ctrl_held, [19] alt_held,
    // [20] caps_on, [23:21] zero
    output logic [23:0]      m_axis_tdata
);

    logic                   accept;
    logic                   is_read;
    logic                   echo_en_reg;
    logic                   out_valid_reg;
    logic                   read_valid_reg;
    ps2a_pkg::char_t        echo_char_reg;
    logic                   echo_valid_reg;
    logic                   key_avail_reg;
    ps2a_pkg::kbd_flags_t   flags_out_reg;
    ps2a_pkg::kbd_flags_t   flags_next;
    ps2a_pkg::char_t        ch;
    ps2a_pkg::char_t        rd_data;
    ps2a_pkg::fifo_status_t fifo_status;
    logic                   have_char;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_read       = s_axis_tuser[0];
    assign have_char     = (ch != '0);

    ps2a_keymap u_keymap (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (accept && !is_read),
        .code       (s_axis_tdata),
        .flags_next (flags_next),
        .ch         (ch)
    );

    ps2a_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_req  (have_char),
        .push_data (ch),
        .pop_req   (accept && is_read),
        .rd_data   (rd_data),
        .status    (fifo_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                echo_en_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_valid_reg <= fifo_status.pop_ok;
            echo_valid_reg <= have_char && echo_en_reg;
            echo_char_reg  <= (have_char && echo_en_reg) ? ch : '0;
            key_avail_reg  <= fifo_status.not_empty;
            flags_out_reg  <= flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            flags_out_reg.caps, flags_out_reg.alt,
                            flags_out_reg.ctrl, flags_out_reg.shift,
                            key_avail_reg,
                            echo_valid_reg, echo_char_reg,
                            read_valid_reg,
                            read_valid_reg ? rd_data : 7'd0};

endmodule
`default_nettype wire

FILE: src/ps2a_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_checker
// Port-level assertions for the scan-code to ASCII unit.
// ----------------------------------------------------------------------------
module ps2a_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no popped character without read_valid
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[6:0] == 7'd0)
        else $error("read_char set without read_valid");

    // echoed character is never zero, and zero when not echoed
    a_echo_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15] == (m_axis_tdata[14:8] != 7'd0)))
        else $error("echo_char and echo_valid disagree");

    // a read item cannot also translate a byte
    a_read_or_echo: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[7] && m_axis_tdata[15]))
        else $error("read and echo in one item");

    // an echoed character leaves the queue non-empty after that item
    a_echo_avail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[16])
        else $error("echoed character but queue empty");

endmodule

bind ps2_scancode_to_ascii_fifo_unit ps2a_checker u_ps2a_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
